// File: rtl/ift_pkg.sv
`default_nettype none

package ift_pkg;

    localparam int CMD_W      = 3;
    localparam int VAL_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 32;
    localparam int WORD_W     = 32;
    localparam int NIB_N      = 16;
    localparam int POS_W      = 4;
    localparam int BCD_N      = 10;
    localparam int BCD_W      = 4 * BCD_N;
    localparam int STEP_W     = 5;
    localparam int QDEPTH     = 2;
    localparam int QAW        = 1;

    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADDR = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
        logic [CNT_W-1:0]  total_chars;
    } t_out;

    typedef struct packed {
        logic [VAL_W-1:0] mag;
        logic             dec;
        logic             neg;
        logic             upper;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_SIGN,
        S_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UA : CHAR_LA;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ift_front.sv
`default_nettype none

module ift_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire ift_pkg::t_in  i_data,
    output logic               o_job_valid,
    input  wire                i_job_ready,
    output ift_pkg::t_job      o_job
);
    import ift_pkg::*;

    logic              r_valid, n_valid;
    t_job              r_job, n_job;
    logic              cmd_ok;
    logic [WORD_W-1:0] low;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;
    assign low         = i_data.value[WORD_W-1:0];

    always_comb begin
        cmd_ok  = 1'b1;
        n_job   = r_job;
        n_valid = r_valid && !i_job_ready;
        unique case (i_data.cmd)
            CMD_SDEC: begin
                n_job.dec   = 1'b1;
                n_job.neg   = low[WORD_W-1];
                n_job.upper = 1'b0;
                n_job.mag   = low[WORD_W-1] ? {{(VAL_W-WORD_W){1'b0}}, ~low + 1'b1}
                                            : {{(VAL_W-WORD_W){1'b0}}, low};
            end
            CMD_UDEC, CMD_HEXL, CMD_HEXU: begin
                n_job.dec   = (i_data.cmd == CMD_UDEC);
                n_job.neg   = 1'b0;
                n_job.upper = (i_data.cmd == CMD_HEXU);
                n_job.mag   = {{(VAL_W-WORD_W){1'b0}}, low};
            end
            CMD_ADDR: begin
                n_job.dec   = 1'b0;
                n_job.neg   = 1'b0;
                n_job.upper = 1'b0;
                n_job.mag   = i_data.value;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
        if (i_valid && o_ready) begin
            n_valid = cmd_ok;
        end else begin
            n_job = r_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

`default_nettype wire

// File: rtl/ift_fifo.sv
`default_nettype none

module ift_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_ready,
    input  wire ift_pkg::t_job i_job,
    output logic               o_valid,
    input  wire                i_pop,
    output ift_pkg::t_job      o_job
);
    import ift_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != QDEPTH[QAW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ift_back.sv
`default_nettype none

module ift_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_job_valid,
    output logic               o_job_ready,
    input  wire ift_pkg::t_job i_job,
    output logic               o_valid,
    input  wire                i_ready,
    output ift_pkg::t_out      o_data
);
    import ift_pkg::*;

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_bin, n_bin;
    logic [VAL_W-1:0]    r_dig, n_dig;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_neg, n_neg;
    logic                r_upper, n_upper;
    logic                r_dec, n_dec;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;
    logic                take, emit;
    logic [3:0]          nib;

    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] t;
        logic [3:0]       d;
        for (int i = 0; i < BCD_N; i++) begin
            d = bcd[4*i +: 4];
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            t[4*i +: 4] = d;
        end
        return {t[BCD_W-2:0], b};
    endfunction

    function automatic logic [POS_W-1:0] msd(input logic [VAL_W-1:0] dig);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < NIB_N; i++) begin
            if (dig[4*i +: 4] != 4'd0) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    assign take        = !r_out_valid || i_ready;
    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign nib         = r_dig[{r_pos, 2'b00} +: 4];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.dec ? S_CONV : S_SCAN;
                end
            end
            S_CONV: begin
                if (r_step == {STEP_W{1'b1}}) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = r_neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (take) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (take && r_pos == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_bin   = r_bin;
        n_dig   = r_dig;
        n_step  = r_step;
        n_pos   = r_pos;
        n_neg   = r_neg;
        n_upper = r_upper;
        n_dec   = r_dec;
        n_count = r_count;
        n_out   = r_out;
        emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_bin   = i_job.mag[WORD_W-1:0];
                    n_dig   = i_job.dec ? '0 : i_job.mag;
                    n_step  = '0;
                    n_neg   = i_job.neg;
                    n_upper = i_job.upper;
                    n_dec   = i_job.dec;
                end
            end
            S_CONV: begin
                n_dig  = {{(VAL_W-BCD_W){1'b0}}, dabble(r_dig[BCD_W-1:0], r_bin[WORD_W-1])};
                n_bin  = {r_bin[WORD_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
            end
            S_SCAN: begin
                n_pos = msd(r_dig);
            end
            S_SIGN: begin
                if (take) begin
                    emit    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_out   = '{char_out: CHAR_MINUS, last: 1'b0, total_chars: r_count + 1'b1};
                end
            end
            S_EMIT: begin
                if (take) begin
                    emit    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_pos   = r_pos - 1'b1;
                    n_out   = '{char_out: digit_char(nib, r_upper), last: (r_pos == '0),
                                total_chars: r_count + 1'b1};
                end
            end
            default: begin
            end
        endcase
        n_out_valid = emit || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_bin   <= n_bin;
        r_dig   <= n_dig;
        r_step  <= n_step;
        r_pos   <= n_pos;
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_dec   <= n_dec;
        r_out   <= n_out;
    end

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_count == $past(r_count) + 1'b1)
        else $error("character count did not advance by one");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) && take |=> r_out_valid && !r_out.last && (r_state == S_EMIT))
        else $error("sign character marked last or not followed by digits");

    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_dec |-> r_dig[VAL_W-1:BCD_W] == '0)
        else $error("decimal digits beyond BCD range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && take && (r_pos == '0) |=> (r_state == S_IDLE) && r_out.last)
        else $error("final digit not flagged or transaction not closed");

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_formatter_unit.sv
`default_nettype none

// Prints one number per input transaction as ASCII, one character per output
// transaction, most significant digit first, no leading zeros, '-' ahead of
// negative signed decimals; last marks the final character and total_chars
// is a wrapping count of all characters sent. Commands 5 to 7 produce nothing.
// A hex item is scanned for its leading digit and then emitted character by
// character; a decimal item first goes through a bit-serial binary-to-BCD conversion.
// Input registration and a two-entry job queue let new items be taken while
// the formatter and its output register are still busy.
module integer_to_ascii_formatter_unit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire ift_pkg::t_in i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output ift_pkg::t_out     o_data
);
    import ift_pkg::*;

    t_job f_job, q_job;
    logic f_valid, f_ready, q_valid, q_pop;

    ift_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    ift_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    ift_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_pop),
        .i_job       (q_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire
